@@ rtl/core/dsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsmc_pkg - display screen mode controller shared definitions
// Screen and event codes, register indexes, and the structs passed between
// the configuration registers, the step logic and the top level.
// ----------------------------------------------------------------------------
package dsmc_pkg;

  typedef enum logic [2:0] {
    SCR_OFF    = 3'd0,
    SCR_SPLASH = 3'd1,
    SCR_LAYOUT = 3'd2,
    SCR_VOLUME = 3'd3,
    SCR_HOME   = 3'd4
  } panel_screen_t;

  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_KEY       = 3'd1;
  localparam logic [2:0] KIND_ENCODER   = 3'd2;
  localparam logic [2:0] KIND_SETTINGS  = 3'd3;
  localparam logic [2:0] KIND_HOUSEKEEP = 3'd4;

  localparam logic [2:0] REG_SPLASH_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_ACTIVITY_QUIET = 3'd1;
  localparam logic [2:0] REG_VOLUME_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_PANEL_TIMEOUT  = 3'd3;
  localparam logic [2:0] REG_CLOCK_DELAY    = 3'd4;
  localparam logic [2:0] REG_SYNC_WINDOW    = 3'd5;

  localparam logic [15:0] SPLASH_TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] ACTIVITY_QUIET_RST = 16'd5000;
  localparam logic [15:0] VOLUME_TIMEOUT_RST = 16'd3000;
  localparam logic [31:0] PANEL_TIMEOUT_RST  = 32'd0;
  localparam logic [31:0] CLOCK_DELAY_RST    = 32'd0;
  localparam logic [15:0] SYNC_WINDOW_RST    = 16'd3000;

  localparam logic [31:0] EXPIRE_USER_MIN_MS = 32'd500;
  localparam logic [31:0] HOME_MIN_MS        = 32'd1000;

  localparam logic signed [1:0] VDIR_UP   = 2'sd1;
  localparam logic signed [1:0] VDIR_NONE = 2'sd0;
  localparam logic signed [1:0] VDIR_DOWN = -2'sd1;

  typedef struct packed {
    logic [15:0] splash_timeout_ms;
    logic [15:0] activity_quiet_ms;
    logic [15:0] volume_timeout_ms;
    logic [31:0] panel_timeout_ms;
    logic [31:0] clock_delay_ms;
    logic [15:0] sync_window_ms;
  } cfg_t;

  typedef struct packed {
    panel_screen_t screen;
    logic [31:0]   screen_age;
    logic [31:0]   user_idle_elapsed;
    logic [31:0]   volume_sync_elapsed;
    logic          volume_recent;
    logic [4:0]    last_layer;
  } state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              display_enabled;
    logic [1:0]        encoder_index;
    logic              clockwise;
    logic signed [1:0] volume_dir;
    logic              matrix_seen;
    logic              key_animation;
    logic [4:0]        layer;
    logic              hid_update;
    logic              volume_moved;
    logic              media_changed;
    logic [31:0]       input_idle_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]        screen;
    logic              panel_on;
    logic              load_screen;
    logic              layout_encoder;
    logic              layout_clockwise;
    logic signed [1:0] volume_step;
    logic              clear_volume_flag;
    logic              housekeep_screen;
  } result_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/core/dsmc_cfg.sv @@
// ----------------------------------------------------------------------------
// dsmc_cfg - configuration register file
// Six timing registers written through an indexed write channel; writes to
// an index beyond the last register are taken and dropped.
// ----------------------------------------------------------------------------
module dsmc_cfg
  import dsmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.splash_timeout_ms <= SPLASH_TIMEOUT_RST;
      cfg.activity_quiet_ms <= ACTIVITY_QUIET_RST;
      cfg.volume_timeout_ms <= VOLUME_TIMEOUT_RST;
      cfg.panel_timeout_ms  <= PANEL_TIMEOUT_RST;
      cfg.clock_delay_ms    <= CLOCK_DELAY_RST;
      cfg.sync_window_ms    <= SYNC_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPLASH_TIMEOUT: cfg.splash_timeout_ms <= cfg_data[15:0];
        REG_ACTIVITY_QUIET: cfg.activity_quiet_ms <= cfg_data[15:0];
        REG_VOLUME_TIMEOUT: cfg.volume_timeout_ms <= cfg_data[15:0];
        REG_PANEL_TIMEOUT:  cfg.panel_timeout_ms  <= cfg_data;
        REG_CLOCK_DELAY:    cfg.clock_delay_ms    <= cfg_data;
        REG_SYNC_WINDOW:    cfg.sync_window_ms    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/dsmc_step.sv @@
// ----------------------------------------------------------------------------
// dsmc_step - screen selection logic for one event
// From the held state, the registers and one event, works out the next
// state and the result beat.
// ----------------------------------------------------------------------------
module dsmc_step
  import dsmc_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  panel_screen_t     c;
  panel_screen_t     want;
  logic [31:0]       se;
  logic [31:0]       ui;
  logic [31:0]       vs;
  logic [31:0]       uidle;
  logic              rec;
  logic [4:0]        ll;
  logic              anim;
  logic              expired;
  logic              load;
  logic              lay_enc;
  logic              lay_cw;
  logic signed [1:0] vstep;
  logic              clr;
  logic              hk;

  always_comb begin
    c       = cur.screen;
    se      = cur.screen_age;
    ui      = cur.user_idle_elapsed;
    vs      = cur.volume_sync_elapsed;
    rec     = cur.volume_recent;
    ll      = cur.last_layer;
    want    = c;
    uidle   = ui;
    anim    = 1'b0;
    expired = 1'b0;
    load    = 1'b0;
    lay_enc = 1'b0;
    lay_cw  = 1'b0;
    vstep   = VDIR_NONE;
    clr     = 1'b0;
    hk      = 1'b0;

    unique case (item.kind)
      KIND_TICK: begin
        se = sat_inc(se);
        ui = sat_inc(ui);
        vs = sat_inc(vs);
      end
      KIND_KEY: begin
        if (item.display_enabled) begin
          ui = '0;
          se = '0;
          if (c != SCR_LAYOUT) begin
            c    = SCR_LAYOUT;
            load = 1'b1;
          end
        end
      end
      KIND_ENCODER: begin
        if (item.encoder_index == 2'd0) begin
          ui = '0;
          if (item.volume_dir != VDIR_NONE) begin
            if (c == SCR_LAYOUT) begin
              lay_enc = 1'b1;
              lay_cw  = item.clockwise;
            end else begin
              vstep = (item.volume_dir == VDIR_UP) ? VDIR_UP : VDIR_DOWN;
              se    = '0;
              vs    = '0;
              rec   = 1'b1;
              if (c != SCR_VOLUME) begin
                c    = SCR_VOLUME;
                load = 1'b1;
              end
            end
          end
        end
      end
      KIND_SETTINGS: begin
        ui = '0;
      end
      KIND_HOUSEKEEP: begin
        if (item.display_enabled) begin
          if (item.matrix_seen) begin
            ui = '0;
            se = '0;
            if (c != SCR_LAYOUT) begin
              c    = SCR_LAYOUT;
              load = 1'b1;
            end
          end
          want = c;
          anim = (c == SCR_LAYOUT) && item.key_animation;
          if (anim) begin
            se = '0;
          end
          if (item.layer != ll) begin
            ll = item.layer;
            ui = '0;
            if (c != SCR_OFF) begin
              want = SCR_LAYOUT;
            end
          end
          uidle = ui;
          if (c != SCR_OFF && item.hid_update) begin
            if (item.volume_moved) begin
              priority if (c == SCR_LAYOUT || want == SCR_LAYOUT) begin
                clr = 1'b1;
                rec = 1'b0;
              end else if (c == SCR_VOLUME || want == SCR_VOLUME) begin
                want = SCR_VOLUME;
                se   = '0;
                rec  = 1'b0;
              end else if (rec && vs < {16'd0, cfg.sync_window_ms}) begin
                clr = 1'b1;
                rec = 1'b0;
              end else begin
                want = SCR_VOLUME;
                se   = '0;
              end
            end
            if (!anim && uidle > {16'd0, cfg.activity_quiet_ms} && item.media_changed) begin
              want = SCR_HOME;
            end
          end
          if (want == c) begin
            expired = (cfg.panel_timeout_ms != 32'd0) &&
                      (item.input_idle_ms > cfg.panel_timeout_ms) &&
                      (uidle > EXPIRE_USER_MIN_MS);
            unique case (c)
              SCR_SPLASH: begin
                if (se > {16'd0, cfg.splash_timeout_ms}) want = SCR_LAYOUT;
              end
              SCR_LAYOUT: begin
                if (expired) begin
                  want = SCR_OFF;
                end else if (cfg.clock_delay_ms != 32'd0 && uidle > cfg.clock_delay_ms) begin
                  want = SCR_HOME;
                end
              end
              SCR_HOME: begin
                if (expired && se > HOME_MIN_MS) want = SCR_OFF;
              end
              SCR_VOLUME: begin
                if (se > {16'd0, cfg.volume_timeout_ms}) want = SCR_HOME;
              end
              default: ;
            endcase
          end
          if (want != c) begin
            se = '0;
            c  = want;
            if (want != SCR_OFF) load = 1'b1;
          end else if (c != SCR_OFF) begin
            hk = 1'b1;
          end
        end
      end
      default: ;
    endcase

    nxt.screen              = c;
    nxt.screen_age          = se;
    nxt.user_idle_elapsed   = ui;
    nxt.volume_sync_elapsed = vs;
    nxt.volume_recent       = rec;
    nxt.last_layer          = ll;

    res.screen            = c;
    res.panel_on          = (c != SCR_OFF);
    res.load_screen       = load;
    res.layout_encoder    = lay_enc;
    res.layout_clockwise  = lay_cw;
    res.volume_step       = vstep;
    res.clear_volume_flag = clr;
    res.housekeep_screen  = hk;
  end

endmodule

@@ rtl/core/display_screen_mode_controller.sv @@
// ----------------------------------------------------------------------------
// display_screen_mode_controller - panel screen selection
// Takes one event beat per cycle (tick, key, encoder, settings change or
// housekeeping) and returns one status beat per event.
//
// Channels: event beats arrive on s_*, kind in s_tuser, the other fields in
// s_tdata. Result beats leave on m_*. Timing registers are written on cfg_*,
// which is always ready; write only while no event is in flight.
// Result: registered, and offered in the cycle after its event beat is accepted.
// Throughput: one event per cycle, set by the single result register; the
// event is applied to the screen state in the cycle it is accepted.
// Reset: screen is splash, all elapsed counters and the last layer are zero,
// registers take their default values, no result is pending.
// Stall: while a result beat waits with m_tready low, s_tready is low and the
// state holds; s_tready is high whenever the result register is empty or
// being emptied in the same cycle.
// ----------------------------------------------------------------------------
module display_screen_mode_controller
  import dsmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] display_enabled, [2:1] encoder_index, [3] clockwise, [5:4] volume_dir,
  // [6] matrix_seen, [7] key_animation, [12:8] layer, [13] hid_update,
  // [14] volume_moved, [15] media_changed, [47:16] input_idle_ms
  input  logic [47:0] s_tdata,
  // [2:0] kind
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] screen, [3] panel_on, [4] load_screen, [5] layout_encoder,
  // [6] layout_clockwise, [8:7] volume_step, [9] clear_volume_flag,
  // [10] housekeep_screen, [15:11] zero
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  result_t res_next;
  result_t res_q;
  logic    accept;

  dsmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign item.kind            = s_tuser;
  assign item.display_enabled = s_tdata[0];
  assign item.encoder_index   = s_tdata[2:1];
  assign item.clockwise       = s_tdata[3];
  assign item.volume_dir      = s_tdata[5:4];
  assign item.matrix_seen     = s_tdata[6];
  assign item.key_animation   = s_tdata[7];
  assign item.layer           = s_tdata[12:8];
  assign item.hid_update      = s_tdata[13];
  assign item.volume_moved    = s_tdata[14];
  assign item.media_changed   = s_tdata[15];
  assign item.input_idle_ms   = s_tdata[47:16];

  dsmc_step u_step (
    .cfg  (cfg),
    .cur  (st),
    .item (item),
    .nxt  (st_next),
    .res  (res_next)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.screen              <= SCR_SPLASH;
      st.screen_age          <= '0;
      st.user_idle_elapsed   <= '0;
      st.volume_sync_elapsed <= '0;
      st.volume_recent       <= 1'b0;
      st.last_layer          <= '0;
      m_tvalid               <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  assign m_tdata = {5'd0, res_q.housekeep_screen, res_q.clear_volume_flag,
                    res_q.volume_step, res_q.layout_clockwise, res_q.layout_encoder,
                    res_q.load_screen, res_q.panel_on, res_q.screen};

  a_panel_matches_screen : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_q.panel_on == (res_q.screen != SCR_OFF)))
    else $error("panel_on disagrees with reported screen");

  a_load_not_off : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.load_screen |-> res_q.screen != SCR_OFF)
    else $error("load pulse reported for the off screen");

  a_encoder_one_target : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.layout_encoder |-> res_q.volume_step == VDIR_NONE)
    else $error("encoder turn handed to both layout and volume");

  a_state_holds_on_stall : assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(st))
    else $error("screen state moved while no beat was taken");

  a_screen_tracks_result : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_q.screen == st.screen)
    else $error("pending result screen differs from held screen");

endmodule
